/* hdl/sha1_pkg.sv */
// Shared constants, types and round functions of the SHA-1 stream hasher.
package sha1_pkg;

  localparam int unsigned CountW = 61;
  localparam int unsigned RoundW = 7;
  localparam int unsigned NumWords = 5;
  localparam int unsigned WindowDepth = 16;

  localparam logic [RoundW-1:0] LastRound = 7'd79;
  localparam logic [RoundW-1:0] ExpandStart = 7'd16;
  localparam logic [RoundW-1:0] Phase2Start = 7'd20;
  localparam logic [RoundW-1:0] Phase3Start = 7'd40;
  localparam logic [RoundW-1:0] Phase4Start = 7'd60;

  localparam logic [5:0] LastBytePos = 6'd63;
  localparam logic [5:0] LenBytePos = 6'd56;
  localparam logic [2:0] LastWordIdx = 3'd4;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [NumWords-1:0][31:0] HInit = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K1 = 32'h5A827999;
  localparam logic [31:0] K2 = 32'h6ED9EBA1;
  localparam logic [31:0] K3 = 32'h8F1BBCDC;
  localparam logic [31:0] K4 = 32'hCA62C1D6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } sha1_state_t;

  typedef struct packed {
    logic              init;
    logic              load;
    logic              step;
    logic              add;
    logic [RoundW-1:0] round;
  } sha1_ctl_t;

  typedef struct packed {
    logic       en;
    logic [5:0] addr;
    logic [7:0] data;
  } sha1_wr_t;

  function automatic logic [31:0] round_f(logic [RoundW-1:0] t, logic [31:0] b,
                                          logic [31:0] c, logic [31:0] d);
    logic [31:0] f;
    if (t < Phase2Start) begin
      f = (b & c) | (~b & d);
    end else if (t < Phase3Start) begin
      f = b ^ c ^ d;
    end else if (t < Phase4Start) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  function automatic logic [31:0] round_k(logic [RoundW-1:0] t);
    logic [31:0] k;
    if (t < Phase2Start) begin
      k = K1;
    end else if (t < Phase3Start) begin
      k = K2;
    end else if (t < Phase4Start) begin
      k = K3;
    end else begin
      k = K4;
    end
    return k;
  endfunction

endpackage

/* hdl/sha1_stream_hasher.sv */
// Top level of the SHA-1 stream hasher: sequencer, padding and digest output.
//
// Each input request carries an optional message byte and an end-of-message
// flag. A byte that does not complete a 64-byte block is stored in the buffer.
// The byte that completes a block starts the compression: 80 rounds on the
// single shared round unit, then the chaining add, during which in_ready is
// low. On end of message the sequencer writes the padding one byte per cycle
// (64 minus the fill level), compresses, and when the length no longer fits
// it pads and compresses a second block. The five digest words then leave
// on the result channel, one per accepted request, index 0 first, the fifth
// marked by out_last_word.
// A stalled receiver holds the block in its output state; no input is taken
// until the last digest word is accepted, after which the hash words return
// to their initial values and the byte count to zero.
// A synchronous reset loads the initial hash values and clears the count.
module sha1_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_byte_valid,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha1_pkg::sha1_state_t state_r, state_nxt;
  logic [sha1_pkg::CountW-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [sha1_pkg::RoundW-1:0] round_r, round_nxt;
  logic [5:0] ptr_r, ptr_nxt, pad_start;
  logic first_r, first_nxt;
  logic lenblk_r, lenblk_nxt;
  logic padding_r, padding_nxt;
  logic eom_r, eom_nxt;
  logic [2:0] widx_r, widx_nxt;
  logic [63:0] len_bits;
  logic [31:0] w_cur;
  logic [sha1_pkg::NumWords-1:0][31:0] hash_words;
  sha1_pkg::sha1_ctl_t ctl;
  sha1_pkg::sha1_wr_t wr;

  assign cnt_inc = cnt_r + {{(sha1_pkg::CountW-1){1'b0}}, 1'b1};
  assign pad_start = in_byte_valid ? cnt_inc[5:0] : cnt_r[5:0];
  assign len_bits = {cnt_r, 3'b000};

  sha1_sched u_sched (
    .clk   (clk),
    .ctl   (ctl),
    .wr    (wr),
    .w_cur (w_cur)
  );

  sha1_round u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .w_cur  (w_cur),
    .hash_o (hash_words)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sha1_pkg::ST_IDLE;
      cnt_r     <= '0;
      round_r   <= '0;
      ptr_r     <= '0;
      first_r   <= 1'b0;
      lenblk_r  <= 1'b0;
      padding_r <= 1'b0;
      eom_r     <= 1'b0;
      widx_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      round_r   <= round_nxt;
      ptr_r     <= ptr_nxt;
      first_r   <= first_nxt;
      lenblk_r  <= lenblk_nxt;
      padding_r <= padding_nxt;
      eom_r     <= eom_nxt;
      widx_r    <= widx_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    round_nxt   = round_r;
    ptr_nxt     = ptr_r;
    first_nxt   = first_r;
    lenblk_nxt  = lenblk_r;
    padding_nxt = padding_r;
    eom_nxt     = eom_r;
    widx_nxt    = widx_r;
    ctl         = '0;
    ctl.round   = round_r;
    wr.en       = 1'b0;
    wr.addr     = cnt_r[5:0];
    wr.data     = in_msg_byte;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    unique case (state_r)
      sha1_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_byte_valid) begin
            wr.en   = 1'b1;
            cnt_nxt = cnt_inc;
          end
          if (in_byte_valid && cnt_r[5:0] == sha1_pkg::LastBytePos) begin
            state_nxt   = sha1_pkg::ST_ROUND;
            ctl.load    = 1'b1;
            round_nxt   = '0;
            padding_nxt = 1'b0;
            eom_nxt     = in_end_of_message;
          end else if (in_end_of_message) begin
            state_nxt  = sha1_pkg::ST_PAD;
            ptr_nxt    = pad_start;
            first_nxt  = 1'b1;
            lenblk_nxt = pad_start < sha1_pkg::LenBytePos;
          end
        end
      end
      sha1_pkg::ST_PAD: begin
        wr.en   = 1'b1;
        wr.addr = ptr_r;
        if (first_r) begin
          wr.data = sha1_pkg::PadByte;
        end else if (lenblk_r && ptr_r >= sha1_pkg::LenBytePos) begin
          wr.data = len_bits[{~ptr_r[2:0], 3'b000} +: 8];
        end else begin
          wr.data = '0;
        end
        first_nxt = 1'b0;
        ptr_nxt   = ptr_r + 6'd1;
        if (ptr_r == sha1_pkg::LastBytePos) begin
          state_nxt   = sha1_pkg::ST_ROUND;
          ctl.load    = 1'b1;
          round_nxt   = '0;
          padding_nxt = 1'b1;
        end
      end
      sha1_pkg::ST_ROUND: begin
        ctl.step  = 1'b1;
        round_nxt = round_r + 7'd1;
        if (round_r == sha1_pkg::LastRound) begin
          state_nxt = sha1_pkg::ST_FINAL;
        end
      end
      sha1_pkg::ST_FINAL: begin
        ctl.add = 1'b1;
        if (padding_r) begin
          if (lenblk_r) begin
            state_nxt = sha1_pkg::ST_OUT;
            widx_nxt  = '0;
          end else begin
            state_nxt  = sha1_pkg::ST_PAD;
            ptr_nxt    = '0;
            first_nxt  = 1'b0;
            lenblk_nxt = 1'b1;
          end
        end else if (eom_r) begin
          state_nxt  = sha1_pkg::ST_PAD;
          ptr_nxt    = cnt_r[5:0];
          first_nxt  = 1'b1;
          lenblk_nxt = cnt_r[5:0] < sha1_pkg::LenBytePos;
        end else begin
          state_nxt = sha1_pkg::ST_IDLE;
        end
      end
      sha1_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          widx_nxt = widx_r + 3'd1;
          if (widx_r == sha1_pkg::LastWordIdx) begin
            ctl.init  = 1'b1;
            cnt_nxt   = '0;
            state_nxt = sha1_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = sha1_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_digest_word = hash_words[widx_r];
  assign out_word_index  = widx_r;
  assign out_last_word   = (widx_r == sha1_pkg::LastWordIdx);

  // The input side and the result side are never open at the same time.
  a_exclusive_channels: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output channels open together");

  // The round counter leaves the compression after the last round, round 79.
  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha1_pkg::ST_ROUND && round_r == sha1_pkg::LastRound)
      |=> (state_r == sha1_pkg::ST_FINAL))
    else $error("compression did not finish after the last round");

  // Once the last digest word is taken, the hasher is ready for a new message.
  a_return_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_word) |=> (in_ready && !out_valid))
    else $error("hasher not idle after the last digest word");

  // A digest word is only presented after a completed length block.
  a_out_after_len: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state_r) == sha1_pkg::ST_FINAL && lenblk_r && padding_r))
    else $error("digest presented without a length block");

endmodule

/* hdl/sha1_sched.sv */
// Block buffer and rolling 16-word message schedule of the SHA-1 hasher.
module sha1_sched (
  input  logic               clk,
  input  sha1_pkg::sha1_ctl_t ctl,
  input  sha1_pkg::sha1_wr_t  wr,
  output logic [31:0]        w_cur
);

  logic [31:0] win_r [sha1_pkg::WindowDepth];
  logic [31:0] mix;

  assign mix = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
  assign w_cur = (ctl.round >= sha1_pkg::ExpandStart) ? {mix[30:0], mix[31]} : win_r[0];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      win_r[wr.addr[5:2]][{~wr.addr[1:0], 3'b000} +: 8] <= wr.data;
    end else if (ctl.step) begin
      for (int i = 0; i < sha1_pkg::WindowDepth - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[sha1_pkg::WindowDepth-1] <= w_cur;
    end
  end

endmodule

/* hdl/sha1_round.sv */
// SHA-1 round unit with working variables and chained hash words.
module sha1_round (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  sha1_pkg::sha1_ctl_t                          ctl,
  input  logic [31:0]                                 w_cur,
  output logic [sha1_pkg::NumWords-1:0][31:0]          hash_o
);

  logic [sha1_pkg::NumWords-1:0][31:0] hash_r;
  logic [sha1_pkg::NumWords-1:0][31:0] vars_r;
  logic [31:0] tmp;

  assign tmp = {vars_r[0][26:0], vars_r[0][31:27]}
             + sha1_pkg::round_f(ctl.round, vars_r[1], vars_r[2], vars_r[3])
             + vars_r[4] + w_cur + sha1_pkg::round_k(ctl.round);

  assign hash_o = hash_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= sha1_pkg::HInit;
    end else if (ctl.init) begin
      hash_r <= sha1_pkg::HInit;
    end else if (ctl.add) begin
      for (int i = 0; i < sha1_pkg::NumWords; i++) begin
        hash_r[i] <= hash_r[i] + vars_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      vars_r <= hash_r;
    end else if (ctl.step) begin
      vars_r[4] <= vars_r[3];
      vars_r[3] <= vars_r[2];
      vars_r[2] <= {vars_r[1][1:0], vars_r[1][31:2]};
      vars_r[1] <= vars_r[0];
      vars_r[0] <= tmp;
    end
  end

endmodule

/* test/sha1_digest_checker.sv */
// Digest checker: watches both channels, predicts every SHA-1 digest word and compares it.
module sha1_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_byte_valid,
  input  logic        in_end_of_message,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_index,
  input  logic        out_last_word,
  output int          fail_count,
  output int          pending_words,
  output int          words_checked
);

  localparam logic [31:0] Iv0 = 32'h67452301;
  localparam logic [31:0] Iv1 = 32'hEFCDAB89;
  localparam logic [31:0] Iv2 = 32'h98BADCFE;
  localparam logic [31:0] Iv3 = 32'h10325476;
  localparam logic [31:0] Iv4 = 32'hC3D2E1F0;

  localparam logic [31:0] ChooseK = 32'h5A827999;
  localparam logic [31:0] ParityK = 32'h6ED9EBA1;
  localparam logic [31:0] MajorityK = 32'h8F1BBCDC;
  localparam logic [31:0] TailK = 32'hCA62C1D6;

  localparam int DigestWords = 5;
  localparam logic [2:0] FinalWordIdx = 3'd4;
  localparam logic [7:0] PadMarker = 8'h80;
  localparam int LenOffset = 56;
  localparam int BlockBytes = 64;
  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [31:0] digest;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  digest_word_t digest_expect_q[$];
  digest_word_t next_word;

  logic [31:0] chain [DigestWords];
  logic [60:0] msg_len;
  logic [7:0]  blk [BlockBytes];

  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, wt, tmp;
    for (int t = 0; t < 16; t++) begin
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        wt = w[(t-3) & 15] ^ w[(t-8) & 15] ^ w[(t-14) & 15] ^ w[t & 15];
        wt = {wt[30:0], wt[31]};
        w[t & 15] = wt;
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = ChooseK;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = ParityK;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = MajorityK;
      end else begin
        f = b ^ c ^ d;
        k = TailK;
      end
      tmp = {a[26:0], a[31:27]} + f + e + wt + k;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = tmp;
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
    chain[4] = chain[4] + e;
  endfunction

  function automatic void start_message();
    chain[0] = Iv0;
    chain[1] = Iv1;
    chain[2] = Iv2;
    chain[3] = Iv3;
    chain[4] = Iv4;
    msg_len = '0;
  endfunction

  function automatic void absorb_byte(logic [7:0] data);
    blk[msg_len[5:0]] = data;
    msg_len = msg_len + 61'd1;
    if (msg_len[5:0] == 6'd0) begin
      compress_block();
    end
  endfunction

  function automatic void close_message();
    int pos;
    logic [63:0] bit_len;
    bit_len = {msg_len, 3'b000};
    pos = int'(msg_len[5:0]);
    blk[pos] = PadMarker;
    pos++;
    if (pos > LenOffset) begin
      for (; pos < BlockBytes; pos++) begin
        blk[pos] = 8'h00;
      end
      compress_block();
      pos = 0;
    end
    for (; pos < LenOffset; pos++) begin
      blk[pos] = 8'h00;
    end
    for (int i = 0; i < 8; i++) begin
      blk[LenOffset + i] = bit_len[63 - 8*i -: 8];
    end
    compress_block();
    for (int i = 0; i < DigestWords; i++) begin
      digest_expect_q.push_back('{digest: chain[i], idx: i[2:0],
                                  last: (i[2:0] == FinalWordIdx)});
    end
    start_message();
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      if (fail_count < ReportLimit) begin
        $display("Mismatch on digest word %0d, %s: expected %h, got %h",
                 words_checked, name, want, got);
      end
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start_message();
      digest_expect_q.delete();
      fail_count = 0;
      words_checked = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (digest_expect_q.size() == 0) begin
          if (fail_count < ReportLimit) begin
            $display("Unexpected digest word %h at index %0d", out_digest_word, out_word_index);
          end
          fail_count++;
        end else begin
          next_word = digest_expect_q.pop_front();
          check_field("digest_word", next_word.digest, out_digest_word);
          check_field("word_index", {29'd0, next_word.idx}, {29'd0, out_word_index});
          check_field("last_word", {31'd0, next_word.last}, {31'd0, out_last_word});
          words_checked++;
        end
      end
      if (in_valid && in_ready) begin
        if (in_byte_valid) begin
          absorb_byte(in_msg_byte);
        end
        if (in_end_of_message) begin
          close_message();
        end
      end
    end
    pending_words = digest_expect_q.size();
  end

endmodule

/* test/sha1_stream_hasher_test.sv */
// Testbench top for the SHA-1 stream hasher: clock, reset, request stimulus and verdict.
module sha1_stream_hasher_test;

  localparam int ItemTarget = 430;
  localparam int DrainCycles = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_msg_byte = 8'h00;
  logic        in_byte_valid = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  int fail_count;
  int pending_words;
  int words_checked;

  int items_sent;
  int messages_sent;
  bit tx_gappy;

  int rx_stall;
  int rx_phase;
  bit rx_choppy;

  always #5 clk = ~clk;

  sha1_stream_hasher dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_msg_byte       (in_msg_byte),
    .in_byte_valid     (in_byte_valid),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word)
  );

  sha1_digest_checker u_digest_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_msg_byte       (in_msg_byte),
    .in_byte_valid     (in_byte_valid),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word),
    .fail_count        (fail_count),
    .pending_words     (pending_words),
    .words_checked     (words_checked)
  );

  // The receiver alternates between always-ready stretches and choppy stretches.
  always @(negedge clk) begin
    if (rx_phase == 0) begin
      rx_choppy <= ($urandom_range(0, 2) != 0);
      rx_phase <= $urandom_range(50, 400);
    end else begin
      rx_phase <= rx_phase - 1;
    end
    if (rx_stall > 0) begin
      out_ready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else if (rx_choppy && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      rx_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_request(input logic bv, input logic [7:0] data, input logic eom);
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte_valid <= bv;
    in_msg_byte <= data;
    in_end_of_message <= eom;
    do begin
      @(posedge clk);
    end while (!in_ready);
    if (bv || eom) begin
      items_sent++;
    end
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_byte_valid <= 1'($urandom_range(0, 1));
      in_msg_byte <= 8'($urandom_range(0, 255));
      in_end_of_message <= 1'($urandom_range(0, 1));
    end
  endtask

  task automatic maybe_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_gappy) begin
      if (r < 30) begin
        idle_cycles($urandom_range(1, 3));
      end else if (r < 33) begin
        idle_cycles($urandom_range(20, 60));
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_words == 0);
  endtask

  task automatic send_message(input int len, input bit eom_on_last);
    for (int i = 0; i < len; i++) begin
      maybe_gap();
      if ($urandom_range(0, 19) == 0) begin
        send_request(1'b0, 8'($urandom_range(0, 255)), 1'b0);
      end
      send_request(1'b1, 8'($urandom_range(0, 255)), eom_on_last && (i == len - 1));
    end
    if (!eom_on_last || len == 0) begin
      maybe_gap();
      send_request(1'b0, 8'($urandom_range(0, 255)), 1'b1);
    end
    messages_sent++;
  endtask

  function automatic int pick_length();
    int r;
    int len;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      len = $urandom_range(0, 12);
    end else if (r < 8) begin
      case ($urandom_range(0, 6))
        0: len = 55;
        1: len = 56;
        2: len = 57;
        3: len = 63;
        4: len = 64;
        5: len = 65;
        default: len = 119;
      endcase
    end else if (r == 8) begin
      len = $urandom_range(13, 70);
    end else begin
      len = $urandom_range(0, 3);
    end
    return len;
  endfunction

  initial begin
    #20_000_000;
    $display("Timeout with %0d digest words still expected.", pending_words);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests: ignored items, the empty message, single bytes at the extremes,
    // the short text "abc", a closing request that carries no byte, and a two-byte message.
    tx_gappy = 1'b0;
    send_request(1'b0, 8'h00, 1'b0);
    send_request(1'b0, 8'hFF, 1'b0);
    send_request(1'b0, 8'hA5, 1'b1);
    send_request(1'b1, 8'h00, 1'b1);
    send_request(1'b1, 8'hFF, 1'b1);
    send_request(1'b1, 8'h61, 1'b0);
    send_request(1'b1, 8'h62, 1'b0);
    send_request(1'b1, 8'h63, 1'b1);
    send_request(1'b1, 8'h5A, 1'b0);
    send_request(1'b0, 8'hC3, 1'b1);
    send_request(1'b1, 8'hAA, 1'b0);
    send_request(1'b1, 8'h55, 1'b1);
    messages_sent = 6;
    drain_results();

    while (items_sent < ItemTarget) begin
      tx_gappy = ($urandom_range(0, 2) != 0);
      send_message(pick_length(), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 5) == 0) begin
        drain_results();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_words == 0);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d requests forming %0d messages, from empty to multi-block.",
             items_sent, messages_sent);
    $display("Compared %0d digest words under random stalls on both channels.", words_checked);
    if (fail_count == 0 && pending_words == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures, %0d digest words never arrived.", fail_count, pending_words);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
